// ===== design/ats_pkg.sv =====
package ats_pkg;

  localparam int MaxEntries   = 4096;
  localparam int FractionBits = 20;
  localparam int RandFracW    = 20;
  localparam int IdxW         = $clog2(MaxEntries);
  localparam int CntW         = $clog2(MaxEntries + 1);
  localparam int EcW          = 13;
  localparam int TwW          = 32;
  localparam int WeightW      = 32;
  localparam int WordW        = 32;
  localparam int ProbW        = 32;
  localparam int ProdW        = WeightW + CntW;
  localparam int DvdW         = ProdW + FractionBits;
  localparam int DsrW         = 32;
  localparam int DivCntW      = $clog2(DvdW + 1);
  localparam int CmpW         = ProbW + RandFracW + FractionBits;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_BUILD  = 2'd1,
    CMD_SAMPLE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_LOADED  = 2'd0,
    ST_BUILT   = 2'd1,
    ST_SAMPLED = 2'd2,
    ST_ERROR   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    RES_LOADED,
    RES_BUILT,
    RES_ERROR,
    RES_SLOT_REM,
    RES_SLOT_CMP
  } res_e;

  typedef struct packed {
    logic capture;
    logic clr_table;
    logic div_start;
    logic load_wr;
    logic b_rd_stacks;
    logic b_rd_pj;
    logic b_rd_pk;
    logic b_wr;
    logic s_rd;
    logic set_built;
    logic out_load;
    res_e res_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic w_zero;
    logic full;
    logic built;
    logic div_done;
    logic stacks_ready;
    logic slot_unloaded;
    logic out_busy;
  } dp_stat_t;

endpackage

// ===== design/ats_div.sv =====
module ats_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ats_pkg::DvdW-1:0]    dividend_i,
  input  logic [ats_pkg::DsrW-1:0]    divisor_i,
  output logic                        done_o,
  output logic [ats_pkg::ProbW-1:0]   quot_o,
  output logic                        ovf_o,
  output logic [ats_pkg::DsrW-1:0]    rem_o
);
  import ats_pkg::*;

  logic [DsrW-1:0]    rem_q, rem_d;
  logic [DvdW-1:0]    dvd_q;
  logic [DsrW-1:0]    dsr_q;
  logic [ProbW-1:0]   quo_q;
  logic               ovf_q;
  logic [DivCntW-1:0] cnt_q;
  logic               run_q, done_q;
  logic [DsrW:0]      rem_sh;
  logic               ge;

  // one restoring step per cycle, remainder always below the divisor
  assign rem_sh = {rem_q, dvd_q[DvdW-1]};
  assign ge     = rem_sh >= {1'b0, dsr_q};
  assign rem_d  = ge ? DsrW'(rem_sh - {1'b0, dsr_q}) : rem_sh[DsrW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= DivCntW'(DvdW);
    end else if (run_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (run_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[DvdW-2:0], 1'b0};
      quo_q <= {quo_q[ProbW-2:0], ge};
      ovf_q <= ovf_q | quo_q[ProbW-1];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign ovf_o  = ovf_q;
  assign rem_o  = rem_q;

endmodule

// ===== design/ats_dp.sv =====
module ats_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ats_pkg::ctrl_cmd_t            cmd_i,
  output ats_pkg::dp_stat_t             stat_o,
  input  logic [1:0]                    in_cmd_i,
  input  logic [ats_pkg::WeightW-1:0]   in_weight_i,
  input  logic [ats_pkg::RandFracW-1:0] in_frac_i,
  input  logic [ats_pkg::WordW-1:0]     in_word_i,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [ats_pkg::TwW-1:0]       cfg_wdata_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [ats_pkg::IdxW-1:0]      out_slot_o,
  output logic [1:0]                    out_status_o
);
  import ats_pkg::*;

  localparam logic [ProbW:0] OneFixed = (ProbW+1)'(1) << FractionBits;

  cmd_e                 cmd_q;
  logic [WeightW-1:0]   w_q;
  logic [RandFracW-1:0] frac_q;
  logic [WordW-1:0]     word_q;
  logic [EcW-1:0]       ec_q;
  logic [TwW-1:0]       tw_q;
  logic [CntW-1:0]      n_eff;
  logic [TwW-1:0]       t_eff;
  logic [ProdW-1:0]     prod_q;

  logic [CntW-1:0] sc_q, lc_q, ldc_q;
  logic            built_q;
  logic [CntW-1:0] sc_m1, lc_m1;
  logic [IdxW-1:0] ld_idx;

  logic [DvdW-1:0]  div_dvd;
  logic [DsrW-1:0]  div_dsr;
  logic             div_done, div_ovf;
  logic [ProbW-1:0] div_quot;
  logic [DsrW-1:0]  div_rem;
  logic [ProbW-1:0] p_new, pk_new;
  logic             p_short, p_long, pk_short;
  logic [IdxW-1:0]  slot;

  logic [ProbW-1:0] prob_mem [MaxEntries];
  logic [IdxW:0]    alias_mem [MaxEntries];
  logic [IdxW-1:0]  short_mem [MaxEntries];
  logic [IdxW-1:0]  long_mem [MaxEntries];

  logic [ProbW-1:0] prob_rd_q, pj_q;
  logic [IdxW:0]    al_rd_q;
  logic [IdxW-1:0]  j_q, k_q;

  logic             prob_we, prob_re, al_we, sh_we, lg_we;
  logic [IdxW-1:0]  prob_wa, prob_ra, al_wa, sh_wa;
  logic [ProbW-1:0] prob_wd;
  logic [IdxW:0]    al_wd;
  logic [IdxW-1:0]  sh_wd;

  logic               le_frac;
  logic [IdxW-1:0]    res_slot;
  status_e            res_status;
  logic               out_valid_q;
  logic [IdxW-1:0]    out_slot_q;
  status_e            out_status_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q  <= cmd_e'(in_cmd_i);
      w_q    <= in_weight_i;
      frac_q <= in_frac_i;
      word_q <= in_word_i;
    end
    prod_q <= ProdW'(w_q) * ProdW'(n_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ec_q <= EcW'(1);
      tw_q <= TwW'(1);
    end else if (cfg_we_i) begin
      if (cfg_idx_i) tw_q <= cfg_wdata_i;
      else           ec_q <= cfg_wdata_i[EcW-1:0];
    end
  end

  always_comb begin
    if (ec_q == '0)                    n_eff = CntW'(1);
    else if (ec_q > EcW'(MaxEntries))  n_eff = CntW'(MaxEntries);
    else                               n_eff = CntW'(ec_q);
  end
  assign t_eff = (tw_q == '0) ? TwW'(1) : tw_q;

  assign sc_m1  = sc_q - 1'b1;
  assign lc_m1  = lc_q - 1'b1;
  assign ld_idx = ldc_q[IdxW-1:0];

  assign div_dvd = (cmd_q == CMD_LOAD) ? {prod_q, FractionBits'(0)} : DvdW'(word_q);
  assign div_dsr = (cmd_q == CMD_LOAD) ? t_eff : DsrW'(n_eff);

  ats_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .ovf_o      (div_ovf),
    .rem_o      (div_rem)
  );

  assign p_new    = div_ovf ? '1 : div_quot;
  assign p_short  = {1'b0, p_new} < OneFixed;
  assign p_long   = {1'b0, p_new} > OneFixed;
  assign pk_new   = ProbW'({1'b0, prob_rd_q} - (OneFixed - {1'b0, pj_q}));
  assign pk_short = {1'b0, pk_new} < OneFixed;
  assign slot     = div_rem[IdxW-1:0];

  // memory port steering
  assign prob_we = cmd_i.load_wr | cmd_i.b_wr;
  assign prob_wa = cmd_i.load_wr ? ld_idx : k_q;
  assign prob_wd = cmd_i.load_wr ? p_new : pk_new;
  assign prob_re = cmd_i.b_rd_pj | cmd_i.b_rd_pk | cmd_i.s_rd;
  assign prob_ra = cmd_i.b_rd_pj ? j_q : (cmd_i.b_rd_pk ? k_q : slot);
  assign al_we   = cmd_i.load_wr | cmd_i.b_wr;
  assign al_wa   = cmd_i.load_wr ? ld_idx : j_q;
  assign al_wd   = cmd_i.load_wr ? '0 : {1'b1, k_q};
  assign sh_we   = (cmd_i.load_wr & p_short) | (cmd_i.b_wr & pk_short);
  assign sh_wa   = cmd_i.load_wr ? sc_q[IdxW-1:0] : sc_m1[IdxW-1:0];
  assign sh_wd   = cmd_i.load_wr ? ld_idx : k_q;
  assign lg_we   = cmd_i.load_wr & p_long;

  always_ff @(posedge clk_i) begin
    if (prob_we) prob_mem[prob_wa] <= prob_wd;
    if (prob_re) prob_rd_q <= prob_mem[prob_ra];
  end

  always_ff @(posedge clk_i) begin
    if (al_we)      alias_mem[al_wa] <= al_wd;
    if (cmd_i.s_rd) al_rd_q <= alias_mem[slot];
  end

  always_ff @(posedge clk_i) begin
    if (sh_we)             short_mem[sh_wa] <= sh_wd;
    if (cmd_i.b_rd_stacks) j_q <= short_mem[sc_m1[IdxW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (lg_we)             long_mem[lc_q[IdxW-1:0]] <= ld_idx;
    if (cmd_i.b_rd_stacks) k_q <= long_mem[lc_m1[IdxW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.b_rd_pk) pj_q <= prob_rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q    <= '0;
      lc_q    <= '0;
      ldc_q   <= '0;
      built_q <= 1'b0;
    end else if (cmd_i.clr_table && built_q) begin
      sc_q    <= '0;
      lc_q    <= '0;
      ldc_q   <= '0;
      built_q <= 1'b0;
    end else if (cmd_i.load_wr) begin
      ldc_q <= ldc_q + 1'b1;
      if (p_short)     sc_q <= sc_q + 1'b1;
      else if (p_long) lc_q <= lc_q + 1'b1;
    end else if (cmd_i.b_wr) begin
      // a reduced long entry that drops below one moves to the short top
      if (pk_short) lc_q <= lc_m1;
      else          sc_q <= sc_m1;
    end else if (cmd_i.set_built) begin
      built_q <= 1'b1;
    end
  end

  assign le_frac = (CmpW'(frac_q) << FractionBits) <= (CmpW'(prob_rd_q) << RandFracW);

  always_comb begin
    res_slot   = '0;
    res_status = ST_ERROR;
    case (cmd_i.res_sel)
      RES_LOADED:   res_status = ST_LOADED;
      RES_BUILT:    res_status = ST_BUILT;
      RES_SLOT_REM: begin
        res_slot   = slot;
        res_status = ST_SAMPLED;
      end
      RES_SLOT_CMP: begin
        res_slot   = (le_frac || !al_rd_q[IdxW]) ? slot : al_rd_q[IdxW-1:0];
        res_status = ST_SAMPLED;
      end
      default:      res_status = ST_ERROR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_slot_q   <= res_slot;
      out_status_q <= res_status;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_slot_o   = out_slot_q;
  assign out_status_o = out_status_q;

  assign stat_o.cmd           = cmd_q;
  assign stat_o.w_zero        = (w_q == '0);
  assign stat_o.full          = (ldc_q >= CntW'(MaxEntries));
  assign stat_o.built         = built_q;
  assign stat_o.div_done      = div_done;
  assign stat_o.stacks_ready  = (sc_q != '0) && (lc_q != '0);
  assign stat_o.slot_unloaded = (CntW'(div_rem) >= ldc_q);
  assign stat_o.out_busy      = out_valid_q && !out_ready_i;

endmodule

// ===== design/ats_ctrl.sv =====
module ats_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ats_pkg::dp_stat_t   stat_i,
  output ats_pkg::ctrl_cmd_t  cmd_o
);
  import ats_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_LD_CHK,
    S_DIV_WAIT,
    S_LD_WR,
    S_S_CHK,
    S_B_CHK,
    S_B_RDJ,
    S_B_RDK,
    S_B_WR,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  res_e   res_q, res_d;
  logic   in_ready;

  assign in_ready = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    cmd_o   = '0;
    cmd_o.capture = in_valid_i && in_ready;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        case (stat_i.cmd)
          CMD_LOAD: begin
            if (stat_i.w_zero) begin
              res_d   = RES_LOADED;
              state_d = S_OUT;
            end else begin
              cmd_o.clr_table = 1'b1;
              state_d         = S_LD_CHK;
            end
          end
          CMD_BUILD:  state_d = S_B_CHK;
          CMD_SAMPLE: begin
            if (!stat_i.built) begin
              res_d   = RES_ERROR;
              state_d = S_OUT;
            end else begin
              cmd_o.div_start = 1'b1;
              state_d         = S_DIV_WAIT;
            end
          end
          default: begin
            res_d   = RES_ERROR;
            state_d = S_OUT;
          end
        endcase
      end
      S_LD_CHK: begin
        if (stat_i.full) begin
          res_d   = RES_ERROR;
          state_d = S_OUT;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (stat_i.div_done) state_d = (stat_i.cmd == CMD_LOAD) ? S_LD_WR : S_S_CHK;
      end
      S_LD_WR: begin
        cmd_o.load_wr = 1'b1;
        res_d         = RES_LOADED;
        state_d       = S_OUT;
      end
      S_S_CHK: begin
        if (stat_i.slot_unloaded) begin
          res_d = RES_SLOT_REM;
        end else begin
          cmd_o.s_rd = 1'b1;
          res_d      = RES_SLOT_CMP;
        end
        state_d = S_OUT;
      end
      S_B_CHK: begin
        if (stat_i.stacks_ready) begin
          cmd_o.b_rd_stacks = 1'b1;
          state_d           = S_B_RDJ;
        end else begin
          cmd_o.set_built = 1'b1;
          res_d           = RES_BUILT;
          state_d         = S_OUT;
        end
      end
      S_B_RDJ: begin
        cmd_o.b_rd_pj = 1'b1;
        state_d       = S_B_RDK;
      end
      S_B_RDK: begin
        cmd_o.b_rd_pk = 1'b1;
        state_d       = S_B_WR;
      end
      S_B_WR: begin
        cmd_o.b_wr = 1'b1;
        state_d    = S_B_CHK;
      end
      S_OUT: begin
        // hold until the output register is free
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    cmd_o.res_sel = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_q   <= RES_ERROR;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  assign in_ready_o = in_ready;

endmodule

// ===== design/alias_table_sampler.sv =====
// Channel   Direction  Payload
// s_axis    in         tdata: weight, rand_fraction, rand_word; tuser: command
// m_axis    out        tdata: slot_index; tuser: status
// cfg       in         write-only: index 0 entry_count, index 1 total_weight
//
// One transaction at a time. Load and sample both run through the one-bit-a-cycle
// divider (65 steps); build repeats a stack read, two probability reads and a write
// for each pairing. Zero-weight, unknown-command and unbuilt-sample results skip the
// divider, as does a load into a full table, which is refused before the divide.
// Reset clears counters and control; table contents need no clearing.
// A pending result sits in the output register while the next transaction is taken.
module alias_table_sampler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,   // weight[31:0], rand_fraction[51:32], rand_word[83:52]
  input  logic [1:0]  s_axis_tuser,   // command[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // slot_index[11:0]
  output logic [1:0]  m_axis_tuser,   // status[1:0]
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);
  import ats_pkg::*;

  ctrl_cmd_t       cmd;
  dp_stat_t        stat;
  logic [IdxW-1:0] slot;

  ats_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ats_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_cmd_i     (s_axis_tuser),
    .in_weight_i  (s_axis_tdata[31:0]),
    .in_frac_i    (s_axis_tdata[51:32]),
    .in_word_i    (s_axis_tdata[83:52]),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_slot_o   (slot),
    .out_status_o (m_axis_tuser)
  );

  assign m_axis_tdata = 16'(slot);

endmodule
